### rtl/mvft_pkg.sv
package mvft_pkg;

    typedef enum logic [2:0] {
        OP_ADD_VERTEX = 3'd0,
        OP_SET_FLAG   = 3'd1,
        OP_GET_FLAG   = 3'd2,
        OP_ADD_FACE   = 3'd3,
        OP_DEL_FACE   = 3'd4,
        OP_CHECK      = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_INVALID   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_FLAG_WAIT,
        S_MOVE,
        S_CHK_ADDR,
        S_CHK_TEST,
        S_DONE
    } t_state;

    localparam int unsigned IDX_W  = 10;
    localparam int unsigned FLAG_W = 32;
    localparam int unsigned CNT_W  = 11;
    localparam int unsigned FACE_W = 3 * IDX_W;

endpackage

### rtl/mesh_vertex_face_table.sv
// Mesh store with a vertex flag table and a face table of index triples, each held in a
// single-port-read RAM. One word in on the slave side gives one word out on the master side.
// Each accepted word passes S_EXEC and then waits in S_DONE until the output register can be
// loaded. Get flag on a present vertex passes S_FLAG_WAIT between them for the registered RAM
// read, removal of a face other than the last passes S_MOVE, and check over a nonempty face
// table walks S_CHK_ADDR and S_CHK_TEST per face, since the face walk reads one face and tests
// it in the next cycle. The block takes no new word until the current one has reached the
// output register and it has gone back to S_IDLE, so it cannot take a new word before it is
// through with the last one. A check stops at the first bad face. Table contents are undefined
// after reset; only entries below the counts are ever read.
module mesh_vertex_face_table
    import mvft_pkg::*;
#(
    parameter int unsigned MAX_VERTICES = 1024,
    parameter int unsigned MAX_FACES    = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [71:0] i_s_tdata,  // vertex_a, vertex_b, vertex_c, face_index, flag_value
    input  logic [2:0]  i_s_tuser,  // operation
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,  // new_id, flag_out, vertices_used, faces_used
    output logic [1:0]  o_m_tuser   // status
);

    localparam int unsigned VAW = $clog2(MAX_VERTICES);
    localparam int unsigned FAW = $clog2(MAX_FACES);
    localparam int unsigned VCW = $clog2(MAX_VERTICES + 1);
    localparam int unsigned FCW = $clog2(MAX_FACES + 1);

    t_state r_state, n_state;

    t_op                r_op;
    logic [IDX_W-1:0]   r_va, r_vb, r_vc, r_fi;
    logic [FLAG_W-1:0]  r_fv;

    logic [VCW-1:0]     r_vertex_total, n_vertex_total;
    logic [FCW-1:0]     r_face_total, n_face_total;
    logic [FAW-1:0]     r_cnt, n_cnt;
    t_status            r_status, n_status;
    logic [IDX_W-1:0]   r_new_id, n_new_id;
    logic [FLAG_W-1:0]  r_flag, n_flag;

    logic               r_m_tvalid;
    logic [63:0]        r_m_tdata;
    logic [1:0]         r_m_tuser;

    // memory ports
    logic               flag_we;
    logic [VAW-1:0]     flag_waddr;
    logic [FLAG_W-1:0]  flag_wdata;
    logic [FLAG_W-1:0]  flag_rdata;
    logic               face_we;
    logic [FAW-1:0]     face_waddr;
    logic [FACE_W-1:0]  face_wdata;
    logic [FAW-1:0]     face_raddr;
    logic [FACE_W-1:0]  face_rdata;

    logic               accept;
    logic               out_load;
    logic [FCW-1:0]     last_face;
    logic               va_miss, vb_miss, vc_miss, fi_miss;
    logic               face_bad;
    logic               walk_end;
    logic [IDX_W-1:0]   ca, cb, cc;

    assign accept   = i_s_tvalid && o_s_tready;
    assign out_load = (r_state == S_DONE) && (!r_m_tvalid || i_m_tready);

    assign last_face = r_face_total - FCW'(1);
    assign va_miss   = 32'(r_va) >= 32'(r_vertex_total);
    assign vb_miss   = 32'(r_vb) >= 32'(r_vertex_total);
    assign vc_miss   = 32'(r_vc) >= 32'(r_vertex_total);
    assign fi_miss   = 32'(r_fi) >= 32'(r_face_total);

    assign ca = face_rdata[IDX_W-1:0];
    assign cb = face_rdata[2*IDX_W-1:IDX_W];
    assign cc = face_rdata[3*IDX_W-1:2*IDX_W];
    assign face_bad = (32'(ca) >= 32'(r_vertex_total)) || (32'(cb) >= 32'(r_vertex_total))
                   || (32'(cc) >= 32'(r_vertex_total))
                   || (ca == cb) || (cb == cc) || (cc == ca);
    assign walk_end = (32'(r_cnt) + 32'd1) == 32'(r_face_total);

    mvft_ram #(.WIDTH(FLAG_W), .DEPTH(MAX_VERTICES)) u_flag_ram (
        .i_clk   (i_clk),
        .i_we    (flag_we),
        .i_waddr (flag_waddr),
        .i_wdata (flag_wdata),
        .i_raddr (VAW'(r_va)),
        .o_rdata (flag_rdata)
    );

    mvft_ram #(.WIDTH(FACE_W), .DEPTH(MAX_FACES)) u_face_ram (
        .i_clk   (i_clk),
        .i_we    (face_we),
        .i_waddr (face_waddr),
        .i_wdata (face_wdata),
        .i_raddr (face_raddr),
        .o_rdata (face_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (r_op)
                    OP_GET_FLAG: begin
                        if (!va_miss) begin
                            n_state = S_FLAG_WAIT;
                        end
                    end
                    OP_DEL_FACE: begin
                        if (!fi_miss && (32'(r_fi) != 32'(last_face))) begin
                            n_state = S_MOVE;
                        end
                    end
                    OP_CHECK: begin
                        if (r_face_total != '0) begin
                            n_state = S_CHK_ADDR;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_FLAG_WAIT: n_state = S_DONE;
            S_MOVE:      n_state = S_DONE;
            S_CHK_ADDR:  n_state = S_CHK_TEST;
            S_CHK_TEST: begin
                if (face_bad || walk_end) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_CHK_ADDR;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_vertex_total = r_vertex_total;
        n_face_total   = r_face_total;
        n_cnt          = r_cnt;
        n_status       = r_status;
        n_new_id       = r_new_id;
        n_flag         = r_flag;
        flag_we        = 1'b0;
        flag_waddr     = VAW'(r_va);
        flag_wdata     = r_fv;
        face_we        = 1'b0;
        face_waddr     = FAW'(r_fi);
        face_wdata     = face_rdata;
        face_raddr     = FAW'(last_face);
        unique case (r_state)
            S_EXEC: begin
                n_status = ST_OK;
                n_new_id = '0;
                n_flag   = '0;
                n_cnt    = '0;
                case (r_op)
                    OP_ADD_VERTEX: begin
                        if (32'(r_vertex_total) >= MAX_VERTICES) begin
                            n_status = ST_FULL;
                        end else begin
                            n_new_id       = IDX_W'(r_vertex_total);
                            flag_we        = 1'b1;
                            flag_waddr     = VAW'(r_vertex_total);
                            flag_wdata     = '0;
                            n_vertex_total = r_vertex_total + VCW'(1);
                        end
                    end
                    OP_SET_FLAG: begin
                        if (va_miss) begin
                            n_status = ST_NOT_FOUND;
                        end else begin
                            flag_we = 1'b1;
                        end
                    end
                    OP_GET_FLAG: begin
                        if (va_miss) begin
                            n_status = ST_NOT_FOUND;
                        end
                    end
                    OP_ADD_FACE: begin
                        if (va_miss || vb_miss || vc_miss) begin
                            n_status = ST_INVALID;
                        end else if (32'(r_face_total) >= MAX_FACES) begin
                            n_status = ST_FULL;
                        end else begin
                            n_new_id     = IDX_W'(r_face_total);
                            face_we      = 1'b1;
                            face_waddr   = FAW'(r_face_total);
                            face_wdata   = {r_vc, r_vb, r_va};
                            n_face_total = r_face_total + FCW'(1);
                        end
                    end
                    OP_DEL_FACE: begin
                        if (fi_miss) begin
                            n_status = ST_NOT_FOUND;
                        end else if (32'(r_fi) == 32'(last_face)) begin
                            n_face_total = last_face;
                        end
                    end
                    OP_CHECK: n_status = ST_OK;
                    default:  n_status = ST_INVALID;
                endcase
            end
            S_FLAG_WAIT: n_flag = flag_rdata;
            S_MOVE: begin
                // last face fills the hole
                face_we      = 1'b1;
                n_face_total = last_face;
            end
            S_CHK_ADDR: face_raddr = r_cnt;
            S_CHK_TEST: begin
                if (face_bad) begin
                    n_status = ST_INVALID;
                end else if (!walk_end) begin
                    n_cnt = r_cnt + FAW'(1);
                end
            end
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_vertex_total <= '0;
            r_face_total   <= '0;
            r_m_tvalid     <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_vertex_total <= n_vertex_total;
            r_face_total   <= n_face_total;
            if (out_load) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= t_op'(i_s_tuser);
            r_va <= i_s_tdata[9:0];
            r_vb <= i_s_tdata[19:10];
            r_vc <= i_s_tdata[29:20];
            r_fi <= i_s_tdata[39:30];
            r_fv <= i_s_tdata[71:40];
        end
        r_cnt    <= n_cnt;
        r_status <= n_status;
        r_new_id <= n_new_id;
        r_flag   <= n_flag;
        if (out_load) begin
            r_m_tuser <= r_status;
            r_m_tdata <= {CNT_W'(r_face_total), CNT_W'(r_vertex_total), r_flag, r_new_id};
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

endmodule

### rtl/mvft_ram.sv
module mvft_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### tb/mesh_vertex_face_table_tb.sv
module mesh_vertex_face_table_tb;
    import mvft_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_V = 1024;
    localparam int unsigned MAX_F = 1024;

    // codes the block must reject
    localparam logic [2:0] OP_RSVD_A = 3'd6;
    localparam logic [2:0] OP_RSVD_B = 3'd7;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  new_id;
        logic [31:0] flag_out;
        logic [10:0] verts;
        logic [10:0] faces;
    } t_mesh_result;

    class mesh_store_tracker;
        logic [31:0]  flag_word [MAX_V];
        logic [9:0]   corner_a [MAX_F];
        logic [9:0]   corner_b [MAX_F];
        logic [9:0]   corner_c [MAX_F];
        int unsigned  vert_count;
        int unsigned  tri_count;
        t_mesh_result awaited [$];
        int           errors;

        function new();
            vert_count = 0;
            tri_count  = 0;
            errors     = 0;
        endfunction

        function bit face_sound(int unsigned f);
            if (corner_a[f] >= vert_count || corner_b[f] >= vert_count ||
                corner_c[f] >= vert_count)
                return 1'b0;
            if (corner_a[f] == corner_b[f] || corner_b[f] == corner_c[f] ||
                corner_c[f] == corner_a[f])
                return 1'b0;
            return 1'b1;
        endfunction

        function void note_op(logic [2:0] op, logic [9:0] va, logic [9:0] vb,
                              logic [9:0] vc, logic [9:0] fi, logic [31:0] fv);
            t_mesh_result r;
            int unsigned  last;
            r = '0;
            r.status = ST_OK;
            case (op)
                OP_ADD_VERTEX: begin
                    if (vert_count >= MAX_V) begin
                        r.status = ST_FULL;
                    end else begin
                        r.new_id = 10'(vert_count);
                        flag_word[vert_count] = '0;
                        vert_count++;
                    end
                end
                OP_SET_FLAG: begin
                    if (va >= vert_count) r.status = ST_NOT_FOUND;
                    else flag_word[va] = fv;
                end
                OP_GET_FLAG: begin
                    if (va >= vert_count) r.status = ST_NOT_FOUND;
                    else r.flag_out = flag_word[va];
                end
                OP_ADD_FACE: begin
                    // corner test comes before the capacity test
                    if (va >= vert_count || vb >= vert_count || vc >= vert_count) begin
                        r.status = ST_INVALID;
                    end else if (tri_count >= MAX_F) begin
                        r.status = ST_FULL;
                    end else begin
                        r.new_id = 10'(tri_count);
                        corner_a[tri_count] = va;
                        corner_b[tri_count] = vb;
                        corner_c[tri_count] = vc;
                        tri_count++;
                    end
                end
                OP_DEL_FACE: begin
                    if (fi >= tri_count) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        // last face is moved into the hole
                        last = tri_count - 1;
                        if (fi != last) begin
                            corner_a[fi] = corner_a[last];
                            corner_b[fi] = corner_b[last];
                            corner_c[fi] = corner_c[last];
                        end
                        tri_count--;
                    end
                end
                OP_CHECK: begin
                    for (int unsigned f = 0; f < tri_count; f++) begin
                        if (!face_sound(f)) begin
                            r.status = ST_INVALID;
                            break;
                        end
                    end
                end
                default: r.status = ST_INVALID;
            endcase
            r.verts = 11'(vert_count);
            r.faces = 11'(tri_count);
            awaited.push_back(r);
        endfunction

        function void check_word(logic [1:0] status, logic [63:0] data);
            t_mesh_result want;
            if (awaited.size() == 0) begin
                $error("result word arrived with nothing awaited");
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, status);
                errors++;
            end
            if (data[9:0] !== want.new_id) begin
                $error("new_id: expected %0d, got %0d", want.new_id, data[9:0]);
                errors++;
            end
            if (data[41:10] !== want.flag_out) begin
                $error("flag_out: expected %h, got %h", want.flag_out, data[41:10]);
                errors++;
            end
            if (data[52:42] !== want.verts) begin
                $error("vertices_used: expected %0d, got %0d", want.verts, data[52:42]);
                errors++;
            end
            if (data[63:53] !== want.faces) begin
                $error("faces_used: expected %0d, got %0d", want.faces, data[63:53]);
                errors++;
            end
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [71:0] i_s_tdata  = '0;  // vertex_a, vertex_b, vertex_c, face_index, flag_value
    logic [2:0]  i_s_tuser  = '0;  // operation
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [63:0] o_m_tdata;        // new_id, flag_out, vertices_used, faces_used
    logic [1:0]  o_m_tuser;        // status

    mesh_store_tracker tracker = new();
    int unsigned       words_sent = 0;
    logic              calm;

    // one long stretch where neither side holds back
    assign calm = (words_sent >= 600 && words_sent < 900);

    mesh_vertex_face_table #(
        .MAX_VERTICES(MAX_V),
        .MAX_FACES   (MAX_F)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_m_tready <= calm || ($urandom_range(99) >= 17);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            tracker.check_word(o_m_tuser, o_m_tdata);
    end

    task automatic send_word(input logic [2:0] op, input logic [9:0] va, input logic [9:0] vb,
                             input logic [9:0] vc, input logic [9:0] fi,
                             input logic [31:0] fv);
        @(negedge i_clk);
        while (!calm && $urandom_range(99) < 17) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {fv, fi, vc, vb, va};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        tracker.note_op(op, va, vb, vc, fi, fv);
        words_sent++;
    endtask

    function automatic logic [9:0] pick_vertex();
        if (tracker.vert_count != 0 && $urandom_range(9) != 0)
            return 10'($urandom_range(tracker.vert_count - 1));
        return 10'($urandom_range(1023));
    endfunction

    task automatic add_random_face(input int unsigned degen_pm);
        logic [9:0] a;
        logic [9:0] b;
        logic [9:0] c;
        int unsigned roll;
        roll = $urandom_range(999);
        if (tracker.vert_count >= 3 && roll >= degen_pm) begin
            a = 10'($urandom_range(tracker.vert_count - 1));
            do b = 10'($urandom_range(tracker.vert_count - 1)); while (b == a);
            do c = 10'($urandom_range(tracker.vert_count - 1)); while (c == a || c == b);
        end else begin
            a = pick_vertex();
            b = pick_vertex();
            c = pick_vertex();
            // repeated corner somewhere in the triple
            case ($urandom_range(2))
                0: b = a;
                1: c = b;
                default: a = c;
            endcase
        end
        send_word(OP_ADD_FACE, a, b, c, 10'($urandom), $urandom);
    endtask

    // weights in parts per thousand; what is left goes to flag access and noise
    task automatic mixed_word(input int unsigned vert_pm, input int unsigned face_pm,
                              input int unsigned del_pm, input int unsigned chk_pm,
                              input int unsigned degen_pm);
        int unsigned roll;
        logic [9:0]  fi;
        roll = $urandom_range(999);
        if (roll < vert_pm) begin
            send_word(OP_ADD_VERTEX, 10'($urandom), 10'($urandom), 10'($urandom),
                      10'($urandom), $urandom);
        end else if (roll < vert_pm + face_pm) begin
            add_random_face(degen_pm);
        end else if (roll < vert_pm + face_pm + del_pm) begin
            if (tracker.tri_count != 0 && $urandom_range(9) != 0)
                fi = ($urandom_range(3) == 0) ? 10'(tracker.tri_count - 1)
                                              : 10'($urandom_range(tracker.tri_count - 1));
            else
                fi = 10'($urandom_range(1023));
            send_word(OP_DEL_FACE, 10'($urandom), 10'($urandom), 10'($urandom), fi, $urandom);
        end else if (roll < vert_pm + face_pm + del_pm + chk_pm) begin
            send_word(OP_CHECK, 10'($urandom), 10'($urandom), 10'($urandom),
                      10'($urandom), $urandom);
        end else begin
            case ($urandom_range(9))
                0, 1, 2, 3:
                    send_word(OP_SET_FLAG, pick_vertex(), 10'($urandom), 10'($urandom),
                              10'($urandom), $urandom);
                4, 5, 6, 7:
                    send_word(OP_GET_FLAG, pick_vertex(), 10'($urandom), 10'($urandom),
                              10'($urandom), $urandom);
                8:
                    send_word(3'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
                              10'($urandom), $urandom);
                default:
                    send_word($urandom_range(1) ? OP_RSVD_A : OP_RSVD_B, 10'($urandom),
                              10'($urandom), 10'($urandom), 10'($urandom), $urandom);
            endcase
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty store: every lookup misses
        send_word(OP_GET_FLAG,  10'd0, 10'd0, 10'd0, 10'd0, 32'h0);
        send_word(OP_SET_FLAG,  10'd0, 10'd0, 10'd0, 10'd0, 32'hFFFF_FFFF);
        send_word(OP_ADD_FACE,  10'd0, 10'd0, 10'd0, 10'd0, 32'h0);
        send_word(OP_DEL_FACE,  10'd0, 10'd0, 10'd0, 10'd0, 32'h0);
        send_word(OP_CHECK,     10'd0, 10'd0, 10'd0, 10'd0, 32'h0);
        send_word(OP_RSVD_A,    10'd0, 10'd0, 10'd0, 10'd0, 32'h0);
        send_word(OP_RSVD_B,    10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF);
        send_word(OP_ADD_VERTEX, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF);
        send_word(OP_ADD_VERTEX, 10'd0, 10'd0, 10'd0, 10'd0, 32'h0);
        send_word(OP_ADD_VERTEX, 10'd0, 10'd0, 10'd0, 10'd0, 32'h0);
        send_word(OP_ADD_VERTEX, 10'd0, 10'd0, 10'd0, 10'd0, 32'h0);
        send_word(OP_GET_FLAG,  10'd2, 10'd0, 10'd0, 10'd0, 32'h0);
        send_word(OP_SET_FLAG,  10'd3, 10'd0, 10'd0, 10'd0, 32'hFFFF_FFFF);
        send_word(OP_SET_FLAG,  10'd4, 10'd0, 10'd0, 10'd0, 32'h1234_5678);
        send_word(OP_GET_FLAG,  10'd3, 10'd0, 10'd0, 10'd0, 32'h0);
        send_word(OP_GET_FLAG,  10'h3FF, 10'd0, 10'd0, 10'd0, 32'h0);
        send_word(OP_ADD_FACE,  10'd0, 10'd1, 10'd2, 10'd0, 32'h0);
        send_word(OP_ADD_FACE,  10'd1, 10'd2, 10'd3, 10'd0, 32'h0);
        send_word(OP_ADD_FACE,  10'd1, 10'h3FF, 10'd2, 10'd0, 32'h0);
        send_word(OP_ADD_FACE,  10'd3, 10'd3, 10'd1, 10'd0, 32'h0);
        send_word(OP_CHECK,     10'd0, 10'd0, 10'd0, 10'd0, 32'h0);
        // removing face 0 pulls the degenerate last face into slot 0
        send_word(OP_DEL_FACE,  10'd0, 10'd0, 10'd0, 10'd0, 32'h0);
        send_word(OP_DEL_FACE,  10'd0, 10'd0, 10'd0, 10'd0, 32'h0);
        send_word(OP_CHECK,     10'd0, 10'd0, 10'd0, 10'd0, 32'h0);
        send_word(OP_DEL_FACE,  10'd0, 10'd0, 10'd0, 10'd0, 32'h0);

        repeat (150) mixed_word(150, 250, 100, 30, 50);

        // fill the face store with sound faces, then push past it
        while (tracker.tri_count < MAX_F) mixed_word(0, 950, 10, 2, 0);
        repeat (4) add_random_face(0);
        repeat (2) send_word(OP_CHECK, 10'($urandom), 10'($urandom), 10'($urandom),
                             10'($urandom), $urandom);

        repeat (100) mixed_word(0, 100, 450, 20, 100);

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (tracker.errors == 0)
            $display("mesh_vertex_face_table_tb: done, clean");
        else
            $display("mesh_vertex_face_table_tb: done, errors");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("mesh_vertex_face_table_tb: done, errors");
        $finish;
    end

endmodule

### files.f
rtl/mvft_pkg.sv
rtl/mvft_ram.sv
rtl/mesh_vertex_face_table.sv
tb/mesh_vertex_face_table_tb.sv
